### design/breadcrumb_trail_follower_top_defines.svh
// Assertion macros used by the trail follower RTL.
`ifndef BREADCRUMB_TRAIL_FOLLOWER_TOP_DEFINES_SVH
`define BREADCRUMB_TRAIL_FOLLOWER_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define BTF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define BTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/btf_pkg.sv
// Types, constants and register codes of the trail follower.
`default_nettype none

package btf_pkg;

  // Default ring depth.
  localparam int unsigned TRAIL_DEPTH_DEF = 64;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FOLLOW_ENABLE = 3'd0;
  localparam logic [2:0] CFG_ADD_SPACING   = 3'd1;
  localparam logic [2:0] CFG_STOP_RADIUS   = 3'd2;
  localparam logic [2:0] CFG_REACH_RADIUS  = 3'd3;
  localparam logic [2:0] CFG_WAIT_RADIUS   = 3'd4;

  // Configuration reset values.
  localparam logic        FOLLOW_ENABLE_RST = 1'b1;
  localparam logic [14:0] ADD_SPACING_RST   = 15'd200;
  localparam logic [14:0] STOP_RADIUS_RST   = 15'd2000;
  localparam logic [14:0] REACH_RADIUS_RST  = 15'd200;
  localparam logic [14:0] WAIT_RADIUS_RST   = 15'd3500;

  typedef struct packed {
    logic        follow_enable;
    logic [14:0] add_spacing_mm;
    logic [14:0] stop_radius_mm;
    logic [14:0] reach_radius_mm;
    logic [14:0] wait_radius_mm;
  } btf_cfg_t;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] robot_x;
    logic signed [15:0] robot_y;
  } btf_in_t;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [6:0]         trail_count;
    logic               wait_warning;
    logic               trail_overflow;
  } btf_out_t;

  // One trail point as stored in the ring.
  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } btf_point_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_R,
    ST_LT_X,
    ST_LT_Y,
    ST_PUSH,
    ST_RT_X,
    ST_RT_Y,
    ST_STOP,
    ST_WAIT,
    ST_RH_X,
    ST_RH_Y,
    ST_POP,
    ST_GOAL,
    ST_DONE
  } btf_state_e;

endpackage

`default_nettype wire

### design/btf_cfg_regs.sv
// Configuration register file of the trail follower.
`default_nettype none

module btf_cfg_regs
  import btf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i,
  output btf_cfg_t         cfg_o
);

  btf_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the write; drop indexes beyond the list.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FOLLOW_ENABLE: cfg_d.follow_enable   = cfg_data_i[0];
        CFG_ADD_SPACING:   cfg_d.add_spacing_mm  = cfg_data_i;
        CFG_STOP_RADIUS:   cfg_d.stop_radius_mm  = cfg_data_i;
        CFG_REACH_RADIUS:  cfg_d.reach_radius_mm = cfg_data_i;
        CFG_WAIT_RADIUS:   cfg_d.wait_radius_mm  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.follow_enable   <= FOLLOW_ENABLE_RST;
      cfg_q.add_spacing_mm  <= ADD_SPACING_RST;
      cfg_q.stop_radius_mm  <= STOP_RADIUS_RST;
      cfg_q.reach_radius_mm <= REACH_RADIUS_RST;
      cfg_q.wait_radius_mm  <= WAIT_RADIUS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

### design/btf_sq_unit.sv
// Shared difference-squarer: registers (a - b)^2 each cycle.
`default_nettype none

module btf_sq_unit
  import btf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic signed [15:0] op_a_i,
  input  wire logic signed [15:0] op_b_i,
  output logic [31:0]             sq_o
);

  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic [31:0]        sq_q;

  // Widen, subtract and square; the square of a 17-bit difference fits 32 bits.
  assign diff = {op_a_i[15], op_a_i} - {op_b_i[15], op_b_i};
  assign prod = diff * diff;

  always_ff @(posedge clk_i) begin
    sq_q <= prod[31:0];
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

### design/btf_trail_mem.sv
// Trail point ring storage: one write port, one registered read port.
`default_nettype none

module btf_trail_mem
  import btf_pkg::*;
#(
  parameter int unsigned TrailDepth = TRAIL_DEPTH_DEF,
  localparam int unsigned AW = (TrailDepth > 1) ? $clog2(TrailDepth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire btf_point_t    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output btf_point_t         rdata_o
);

  btf_point_t mem [TrailDepth];
  btf_point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/btf_seq.sv
// Sequencer and trail state of the follower: one square per step.
`default_nettype none

`include "breadcrumb_trail_follower_top_defines.svh"

module btf_seq
  import btf_pkg::*;
#(
  parameter int unsigned TrailDepth = TRAIL_DEPTH_DEF,
  localparam int unsigned AW = (TrailDepth > 1) ? $clog2(TrailDepth) : 1,
  localparam int unsigned CW = $clog2(TrailDepth + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire btf_cfg_t      cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire btf_in_t       in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output btf_out_t           out_item_o,
  output logic signed [15:0] sq_a_o,
  output logic signed [15:0] sq_b_o,
  input  wire logic [31:0]   sq_i,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output btf_point_t         mem_wdata_o,
  output logic [AW-1:0]      mem_raddr_o,
  input  wire btf_point_t    mem_rdata_i
);

  btf_state_e state_q, state_d;

  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  btf_point_t    last_q, last_d, goal_q, goal_d;
  logic          out_valid_q, out_valid_d;
  btf_out_t      out_q, out_d;

  btf_in_t       item_q, item_d;
  logic [29:0]   rsq_q, rsq_d;
  logic [31:0]   part_q, part_d;
  logic [32:0]   dist_q, dist_d;
  logic          warn_q, warn_d, ovf_q, ovf_d;

  logic          accept;
  logic          slot_free;
  logic [32:0]   dsum;
  logic [32:0]   rsq_ext;
  logic          ring_full;
  logic          stop_hit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Add the two partial squares of a distance.
  assign dsum      = {1'b0, part_q} + {1'b0, sq_i};
  assign rsq_ext   = {3'b000, rsq_q};
  assign ring_full = (count_q == CW'(TrailDepth));
  assign stop_hit  = (dsum < rsq_ext) || (count_q == '0);

  assign mem_waddr_o = wr_ptr_q;
  assign mem_wdata_o = '{y: item_q.target_y, x: item_q.target_x};
  assign mem_raddr_o = rd_ptr_d;

  // Advance the step sequence.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = cfg_i.follow_enable ? ST_ADD_R : ST_DONE;
      ST_ADD_R: state_d = ST_LT_X;
      ST_LT_X:  state_d = ST_LT_Y;
      ST_LT_Y:  state_d = ST_PUSH;
      ST_PUSH:  state_d = ST_RT_X;
      ST_RT_X:  state_d = ST_RT_Y;
      ST_RT_Y:  state_d = ST_STOP;
      ST_STOP:  state_d = stop_hit ? ST_DONE : ST_WAIT;
      ST_WAIT:  state_d = ST_RH_X;
      ST_RH_X:  state_d = ST_RH_Y;
      ST_RH_Y:  state_d = ST_POP;
      ST_POP:   state_d = ST_GOAL;
      ST_GOAL:  state_d = ST_DONE;
      ST_DONE:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Drive the squarer and memory, and update the trail per step.
  always_comb begin
    sq_a_o      = '0;
    sq_b_o      = '0;
    mem_we_o    = 1'b0;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    count_d     = count_q;
    last_d      = last_q;
    goal_d      = goal_q;
    out_d       = out_q;
    item_d      = item_q;
    rsq_d       = rsq_q;
    part_d      = part_q;
    dist_d      = dist_q;
    warn_d      = warn_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = in_item_i;
          warn_d = 1'b0;
          ovf_d  = 1'b0;
        end
      end
      ST_ADD_R: begin
        sq_a_o = {1'b0, cfg_i.add_spacing_mm};
      end
      ST_LT_X: begin
        rsq_d  = sq_i[29:0];
        sq_a_o = last_q.x;
        sq_b_o = item_q.target_x;
      end
      ST_LT_Y: begin
        part_d = sq_i;
        sq_a_o = last_q.y;
        sq_b_o = item_q.target_y;
      end
      ST_PUSH: begin
        sq_a_o = {1'b0, cfg_i.stop_radius_mm};
        if ((count_q == '0) || (dsum > rsq_ext)) begin
          if (ring_full) begin
            ovf_d = 1'b1;
          end else begin
            mem_we_o = 1'b1;
            wr_ptr_d = (wr_ptr_q == AW'(TrailDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
            count_d  = count_q + 1'b1;
            last_d   = '{y: item_q.target_y, x: item_q.target_x};
          end
        end
      end
      ST_RT_X: begin
        rsq_d  = sq_i[29:0];
        sq_a_o = item_q.robot_x;
        sq_b_o = item_q.target_x;
      end
      ST_RT_Y: begin
        part_d = sq_i;
        sq_a_o = item_q.robot_y;
        sq_b_o = item_q.target_y;
      end
      ST_STOP: begin
        dist_d = dsum;
        if (stop_hit) begin
          goal_d = '{y: item_q.robot_y, x: item_q.robot_x};
        end else begin
          sq_a_o = {1'b0, cfg_i.wait_radius_mm};
        end
      end
      ST_WAIT: begin
        warn_d = dist_q > {1'b0, sq_i};
        sq_a_o = {1'b0, cfg_i.reach_radius_mm};
      end
      ST_RH_X: begin
        rsq_d  = sq_i[29:0];
        sq_a_o = item_q.robot_x;
        sq_b_o = mem_rdata_i.x;
      end
      ST_RH_Y: begin
        part_d = sq_i;
        sq_a_o = item_q.robot_y;
        sq_b_o = mem_rdata_i.y;
      end
      ST_POP: begin
        if (dsum < rsq_ext) begin
          rd_ptr_d = (rd_ptr_q == AW'(TrailDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
          count_d  = count_q - 1'b1;
        end
      end
      ST_GOAL: begin
        // Keep the previous goal once the ring runs empty.
        if (count_q != '0) begin
          goal_d = mem_rdata_i;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_d.goal_x         = goal_q.x;
          out_d.goal_y         = goal_q.y;
          out_d.trail_count    = 7'(count_q);
          out_d.wait_warning   = warn_q;
          out_d.trail_overflow = ovf_q;
        end
      end
      default: ;
    endcase
  end

  // Hold control and trail state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      count_q     <= '0;
      last_q      <= '0;
      goal_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      last_q      <= last_d;
      goal_q      <= goal_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working values of the item in flight.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rsq_q  <= rsq_d;
    part_q <= part_d;
    dist_q <= dist_d;
    warn_q <= warn_d;
    ovf_q  <= ovf_d;
    out_q  <= out_d;
  end

  `BTF_ASSERT(a_count_bound, count_q <= CW'(TrailDepth), "trail count beyond ring depth")
  `BTF_ASSERT(a_pop_nonempty, state_q == ST_POP && dsum < rsq_ext |-> count_q != '0, "empty pop")
  `BTF_ASSERT_NXT(a_accept_busy, accept, state_q != ST_IDLE, "item did not start")
  `BTF_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result not from done")

endmodule

`default_nettype wire

### design/breadcrumb_trail_follower_top.sv
// Result: with following off, an accepted item goes straight to the done state; otherwise the goal
// is the robot position when the stop check hits, else the trail head is checked for a pop first.
// Items: one at a time; the next is stalled until the last is through, paced by the single shared
// squarer (one square per cycle) and the registered read of the trail memory.
// Reset: asynchronous, active low; clears pointers, count, last point and goal, loads config defaults.
`default_nettype none

module breadcrumb_trail_follower_top
  import btf_pkg::*;
#(
  parameter int unsigned TRAIL_DEPTH = TRAIL_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire btf_in_t     in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output btf_out_t         out_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i
);

  localparam int unsigned AW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;

  btf_cfg_t           cfg;
  logic signed [15:0] sq_a, sq_b;
  logic [31:0]        sq;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  btf_point_t         mem_wdata, mem_rdata;

  btf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  btf_sq_unit u_sq (
    .clk_i  (clk_i),
    .op_a_i (sq_a),
    .op_b_i (sq_b),
    .sq_o   (sq)
  );

  btf_trail_mem #(
    .TrailDepth (TRAIL_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  btf_seq #(
    .TrailDepth (TRAIL_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .sq_a_o      (sq_a),
    .sq_b_o      (sq_b),
    .sq_i        (sq),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

`default_nettype wire
